[rtl/rtpp_pkg.sv]
// ============================================================================
// rtpp_pkg
// Shared types and constants for the rigid transform of points and planes.
// ============================================================================
package rtpp_pkg;

    localparam int ROT_REG_W     = 54;
    localparam int COORD_FRAC    = 16;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_ADDR_W    = 6;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_IDX_LSB   = 3;
    localparam int PROD_LIM_LOG2 = 60;

    localparam logic [ROT_REG_W-1:0] ROT_COL0_RST = ROT_REG_W'(65536);
    localparam logic [ROT_REG_W-1:0] ROT_COL1_RST = ROT_REG_W'(64'd4294967296);
    localparam logic [ROT_REG_W-1:0] ROT_COL2_RST = ROT_REG_W'(64'd281474976710656);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROT_COL0 = 3'd0,
        REG_ROT_COL1 = 3'd1,
        REG_ROT_COL2 = 3'd2,
        REG_TRANS_X  = 3'd3,
        REG_TRANS_Y  = 3'd4,
        REG_TRANS_Z  = 3'd5
    } t_cfg_reg;

    typedef enum logic {
        OP_POINT = 1'b0,
        OP_PLANE = 1'b1
    } t_opcode;

    typedef struct packed {
        logic valid;
        logic plane;
        logic sat;
    } t_stage_ctl;

endpackage

[rtl/rtpp_pt_if.sv]
// ============================================================================
// rtpp_pt_if
// Input channel: one point or plane equation per beat.
// ============================================================================
interface rtpp_pt_if #(
    parameter int CW = 32
) ();
    logic                 valid;
    logic                 ready;
    logic                 opcode;
    logic signed [CW-1:0] in_x;
    logic signed [CW-1:0] in_y;
    logic signed [CW-1:0] in_z;
    logic signed [CW-1:0] in_dist;

    modport source (output valid, opcode, in_x, in_y, in_z, in_dist, input ready);
    modport sink   (input valid, opcode, in_x, in_y, in_z, in_dist, output ready);
endinterface

[rtl/rtpp_res_if.sv]
// ============================================================================
// rtpp_res_if
// Result channel: one transformed vector and distance per beat.
// ============================================================================
interface rtpp_res_if #(
    parameter int CW = 32
) ();
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] out_x;
    logic signed [CW-1:0] out_y;
    logic signed [CW-1:0] out_z;
    logic signed [CW-1:0] out_dist;
    logic                 saturated;

    modport source (output valid, out_x, out_y, out_z, out_dist, saturated, input ready);
    modport sink   (input valid, out_x, out_y, out_z, out_dist, saturated, output ready);
endinterface

[rtl/rtpp_regs.sv]
// ============================================================================
// rtpp_regs
// APB register file: rotation columns and translation, entry decode.
// ============================================================================
module rtpp_regs #(
    parameter int CW = 32,
    parameter int RW = 18
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rtpp_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [rtpp_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [rtpp_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready,
    output logic signed [RW-1:0]              o_rot [3][3],
    output logic signed [CW-1:0]              o_trans [3]
);
    import rtpp_pkg::*;

    localparam int PADW = (3 * RW > ROT_REG_W) ? 3 * RW : ROT_REG_W;

    logic [ROT_REG_W-1:0]  r_rot_col [3];
    logic signed [CW-1:0]  r_trans [3];
    logic                  wr;
    t_cfg_reg              idx;
    logic [PADW-1:0]       col_pad [3];

    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite;
    assign idx    = t_cfg_reg'(paddr[CFG_IDX_LSB +: CFG_IDX_W]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot_col[0] <= ROT_COL0_RST;
            r_rot_col[1] <= ROT_COL1_RST;
            r_rot_col[2] <= ROT_COL2_RST;
            r_trans[0]   <= '0;
            r_trans[1]   <= '0;
            r_trans[2]   <= '0;
        end else if (wr) begin
            case (idx)
                REG_ROT_COL0: r_rot_col[0] <= pwdata[ROT_REG_W-1:0];
                REG_ROT_COL1: r_rot_col[1] <= pwdata[ROT_REG_W-1:0];
                REG_ROT_COL2: r_rot_col[2] <= pwdata[ROT_REG_W-1:0];
                REG_TRANS_X:  r_trans[0]   <= pwdata[CW-1:0];
                REG_TRANS_Y:  r_trans[1]   <= pwdata[CW-1:0];
                REG_TRANS_Z:  r_trans[2]   <= pwdata[CW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_ROT_COL0: prdata = {{(CFG_DATA_W-ROT_REG_W){1'b0}}, r_rot_col[0]};
            REG_ROT_COL1: prdata = {{(CFG_DATA_W-ROT_REG_W){1'b0}}, r_rot_col[1]};
            REG_ROT_COL2: prdata = {{(CFG_DATA_W-ROT_REG_W){1'b0}}, r_rot_col[2]};
            REG_TRANS_X:  prdata = {{(CFG_DATA_W-CW){r_trans[0][CW-1]}}, r_trans[0]};
            REG_TRANS_Y:  prdata = {{(CFG_DATA_W-CW){r_trans[1][CW-1]}}, r_trans[1]};
            REG_TRANS_Z:  prdata = {{(CFG_DATA_W-CW){r_trans[2][CW-1]}}, r_trans[2]};
            default:      prdata = '0;
        endcase
    end

    // entries past the top of a column read as zero bits
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            col_pad[c] = PADW'(r_rot_col[c]);
            o_trans[c] = r_trans[c];
        end
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                o_rot[r][c] = signed'(col_pad[c][r*RW +: RW]);
            end
        end
    end

endmodule

[rtl/rtpp_xform.sv]
// ============================================================================
// rtpp_xform
// Stages 1-3: rotation products, sums with translation, plane correction
// vector, clamp to coordinate width.
// ============================================================================
module rtpp_xform #(
    parameter int CW = 32,
    parameter int RF = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic                   i_opcode,
    input  logic signed [CW-1:0]   i_v [3],
    input  logic signed [CW-1:0]   i_dist,
    input  logic signed [RF+1:0]   i_rot [3][3],
    input  logic signed [CW-1:0]   i_trans [3],
    output rtpp_pkg::t_stage_ctl   o_ctl,
    output logic signed [CW-1:0]   o_vec [3],
    output logic signed [CW-1:0]   o_td [3],
    output logic signed [CW-1:0]   o_v [3],
    output logic signed [CW-1:0]   o_dist
);
    import rtpp_pkg::*;

    localparam int RW = RF + 2;
    localparam int PW = RW + CW;
    localparam int QW = PW - RF;
    localparam int AW = CW + 4;
    localparam logic signed [PW-1:0] BIAS = {{(PW-RF){1'b0}}, {RF{1'b1}}};
    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

    function automatic logic signed [QW-1:0] trunc_shr(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] b;
        b = p + (p[PW-1] ? BIAS : '0);
        return QW'(b >>> RF);
    endfunction

    function automatic logic clamp_ovf(input logic signed [AW-1:0] a);
        return (a[AW-1:CW-1] != '0) && (a[AW-1:CW-1] != '1);
    endfunction

    function automatic logic signed [CW-1:0] clamp_val(input logic signed [AW-1:0] a);
        if (clamp_ovf(a)) begin
            return a[AW-1] ? CMIN : CMAX;
        end
        return a[CW-1:0];
    endfunction

    // stage 1
    logic                  r1_valid, r1_plane;
    logic signed [PW-1:0]  r1_prod_v [3][3];
    logic signed [PW-1:0]  r1_prod_t [3][3];
    logic signed [CW-1:0]  r1_v [3];
    logic signed [CW-1:0]  r1_dist;
    logic signed [PW-1:0]  n1_prod_v [3][3];
    logic signed [PW-1:0]  n1_prod_t [3][3];

    // stage 2
    logic                  r2_valid, r2_plane;
    logic signed [AW-1:0]  r2_acc [3];
    logic signed [AW-1:0]  r2_td [3];
    logic signed [CW-1:0]  r2_v [3];
    logic signed [CW-1:0]  r2_dist;
    logic signed [AW-1:0]  n2_acc [3];
    logic signed [AW-1:0]  n2_td [3];

    // stage 3
    t_stage_ctl            r3_ctl;
    logic signed [CW-1:0]  r3_vec [3];
    logic signed [CW-1:0]  r3_td [3];
    logic signed [CW-1:0]  r3_v [3];
    logic signed [CW-1:0]  r3_dist;
    logic                  n3_sat;
    logic signed [CW-1:0]  n3_vec [3];
    logic signed [CW-1:0]  n3_td [3];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                n1_prod_v[r][c] = PW'(i_rot[r][c] * i_v[c]);
                n1_prod_t[r][c] = PW'(i_rot[r][c] * i_trans[r]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_plane  <= (t_opcode'(i_opcode) == OP_PLANE);
            r1_prod_v <= n1_prod_v;
            r1_prod_t <= n1_prod_t;
            r1_v      <= i_v;
            r1_dist   <= i_dist;
        end
    end

    // correction uses R^T * (-t); truncation toward zero is odd-symmetric
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n2_acc[r] = r1_plane ? '0 : AW'(i_trans[r]);
            for (int c = 0; c < 3; c++) begin
                n2_acc[r] = n2_acc[r] + AW'(trunc_shr(r1_prod_v[r][c]));
            end
        end
        for (int c = 0; c < 3; c++) begin
            n2_td[c] = '0;
            for (int r = 0; r < 3; r++) begin
                n2_td[c] = n2_td[c] - AW'(trunc_shr(r1_prod_t[r][c]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_plane <= r1_plane;
            r2_acc   <= n2_acc;
            r2_td    <= n2_td;
            r2_v     <= r1_v;
            r2_dist  <= r1_dist;
        end
    end

    always_comb begin
        n3_sat = 1'b0;
        for (int k = 0; k < 3; k++) begin
            n3_vec[k] = clamp_val(r2_acc[k]);
            n3_td[k]  = clamp_val(r2_td[k]);
            n3_sat    = n3_sat | clamp_ovf(r2_acc[k]) | (r2_plane & clamp_ovf(r2_td[k]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_ctl <= '0;
        end else if (i_en) begin
            r3_ctl.valid <= r2_valid;
            r3_ctl.plane <= r2_plane;
            r3_ctl.sat   <= n3_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_vec  <= n3_vec;
            r3_td   <= n3_td;
            r3_v    <= r2_v;
            r3_dist <= r2_dist;
        end
    end

    assign o_ctl  = r3_ctl;
    assign o_vec  = r3_vec;
    assign o_td   = r3_td;
    assign o_v    = r3_v;
    assign o_dist = r3_dist;

endmodule

[rtl/rtpp_plane.sv]
// ============================================================================
// rtpp_plane
// Stages 4-6: plane distance correction n . td, accumulate, clamp.
// ============================================================================
module rtpp_plane #(
    parameter int CW = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  rtpp_pkg::t_stage_ctl   i_ctl,
    input  logic signed [CW-1:0]   i_vec [3],
    input  logic signed [CW-1:0]   i_td [3],
    input  logic signed [CW-1:0]   i_v [3],
    input  logic signed [CW-1:0]   i_dist,
    output rtpp_pkg::t_stage_ctl   o_ctl,
    output logic signed [CW-1:0]   o_vec [3],
    output logic signed [CW-1:0]   o_dist
);
    import rtpp_pkg::*;

    localparam int PW  = 2 * CW;
    localparam int QW  = PW - COORD_FRAC;
    localparam int LW  = (QW > PROD_LIM_LOG2 + 2) ? QW : PROD_LIM_LOG2 + 2;
    localparam int AW  = LW + 2;
    localparam logic signed [PW-1:0] BIAS = {{(PW-COORD_FRAC){1'b0}}, {COORD_FRAC{1'b1}}};
    localparam logic signed [LW-1:0] LIM  =
        {{(LW-PROD_LIM_LOG2-1){1'b0}}, 1'b1, {PROD_LIM_LOG2{1'b0}}};
    localparam logic signed [LW-1:0] NLIM = -LIM;
    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

    function automatic logic signed [LW-1:0] prod_shr(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] b;
        logic signed [LW-1:0] q;
        b = p + (p[PW-1] ? BIAS : '0);
        q = LW'(QW'(b >>> COORD_FRAC));
        if (q > LIM) begin
            q = LIM;
        end else if (q < NLIM) begin
            q = NLIM;
        end
        return q;
    endfunction

    // stage 4
    t_stage_ctl            r4_ctl;
    logic signed [PW-1:0]  r4_prod [3];
    logic signed [CW-1:0]  r4_vec [3];
    logic signed [CW-1:0]  r4_dist;
    logic signed [PW-1:0]  n4_prod [3];

    // stage 5
    t_stage_ctl            r5_ctl;
    logic signed [AW-1:0]  r5_acc;
    logic signed [CW-1:0]  r5_vec [3];
    logic signed [AW-1:0]  n5_acc;

    // stage 6
    t_stage_ctl            r6_ctl;
    logic signed [CW-1:0]  r6_vec [3];
    logic signed [CW-1:0]  r6_dist;
    logic                  n6_ovf;
    logic signed [CW-1:0]  n6_dist;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n4_prod[k] = PW'(i_v[k] * i_td[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_ctl <= '0;
        end else if (i_en) begin
            r4_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_prod <= n4_prod;
            r4_vec  <= i_vec;
            r4_dist <= i_dist;
        end
    end

    always_comb begin
        n5_acc = AW'(r4_dist);
        for (int k = 0; k < 3; k++) begin
            n5_acc = n5_acc + AW'(prod_shr(r4_prod[k]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_ctl <= '0;
        end else if (i_en) begin
            r5_ctl <= r4_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_acc <= n5_acc;
            r5_vec <= r4_vec;
        end
    end

    always_comb begin
        n6_ovf = (r5_acc[AW-1:CW-1] != '0) && (r5_acc[AW-1:CW-1] != '1);
        if (!r5_ctl.plane) begin
            n6_dist = '0;
        end else if (n6_ovf) begin
            n6_dist = r5_acc[AW-1] ? CMIN : CMAX;
        end else begin
            n6_dist = r5_acc[CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_ctl <= '0;
        end else if (i_en) begin
            r6_ctl.valid <= r5_ctl.valid;
            r6_ctl.plane <= r5_ctl.plane;
            r6_ctl.sat   <= r5_ctl.sat | (r5_ctl.plane & n6_ovf);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_vec  <= r5_vec;
            r6_dist <= n6_dist;
        end
    end

    assign o_ctl  = r6_ctl;
    assign o_vec  = r6_vec;
    assign o_dist = r6_dist;

endmodule

[rtl/rtpp_skid.sv]
// ============================================================================
// rtpp_skid
// Output register with one skid entry; upstream ready is registered.
// ============================================================================
module rtpp_skid #(
    parameter int DW = 129
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [DW-1:0] i_data,
    output logic          o_ready,
    output logic          o_valid,
    output logic [DW-1:0] o_data,
    input  logic          i_ready
);
    logic          r_out_valid;
    logic          r_skid_valid;
    logic [DW-1:0] r_out_data;
    logic [DW-1:0] r_skid_data;
    logic          take;

    assign o_ready = ~r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;
    assign take    = ~r_out_valid | i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (take) begin
            r_out_valid  <= r_skid_valid | i_valid;
            r_skid_valid <= 1'b0;
        end else if (i_valid && !r_skid_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_data <= r_skid_valid ? r_skid_data : i_data;
        end else if (i_valid && !r_skid_valid) begin
            r_skid_data <= i_data;
        end
    end

endmodule

[rtl/rigid_transform_points_planes.sv]
// ============================================================================
// rigid_transform_points_planes
// Rigid transform of points (R*p + t) and plane equations (R*n,
// d + n . R^T(-t)) in fixed point, saturating, one beat per clock.
//
//   channel   direction  handshake              payload
//   i_pt      in         valid/ready            opcode, in_x/y/z, in_dist
//   o_res     out        valid/ready            out_x/y/z, out_dist, saturated
//   APB       in/out     psel/penable/pready    64-bit regs at 8*index
//
// One beat per cycle sustained while the output accepts. A result passes
// through six pipeline stages (two multiplier ranks) and then the output
// register. A stalled output fills the skid entry; the pipeline then holds
// as a whole and i_pt.ready drops. Synchronous active-low reset empties the
// pipeline, holds i_pt.ready low and restores the register reset values.
// ============================================================================
module rigid_transform_points_planes #(
    parameter int COORD_WIDTH   = 32,
    parameter int ROT_FRAC_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rtpp_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [rtpp_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [rtpp_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                             pready,
    rtpp_pt_if.sink                          i_pt,
    rtpp_res_if.source                       o_res
);
    import rtpp_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int RW = ROT_FRAC_BITS + 2;
    localparam int DW = 4 * CW + 1;

    logic signed [RW-1:0] rot [3][3];
    logic signed [CW-1:0] trans [3];
    logic signed [CW-1:0] vin [3];
    logic                 en;

    t_stage_ctl           ctl3, ctl6;
    logic signed [CW-1:0] vec3 [3];
    logic signed [CW-1:0] td3 [3];
    logic signed [CW-1:0] v3 [3];
    logic signed [CW-1:0] dist3;
    logic signed [CW-1:0] vec6 [3];
    logic signed [CW-1:0] dist6;
    logic [DW-1:0]        res_data;
    logic [DW-1:0]        out_data;

    rtpp_regs #(.CW(CW), .RW(RW)) u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_rot   (rot),
        .o_trans (trans)
    );

    assign vin[0]     = i_pt.in_x;
    assign vin[1]     = i_pt.in_y;
    assign vin[2]     = i_pt.in_z;
    assign i_pt.ready = en & i_rst_n;

    rtpp_xform #(.CW(CW), .RF(ROT_FRAC_BITS)) u_xform (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_pt.valid),
        .i_opcode (i_pt.opcode),
        .i_v      (vin),
        .i_dist   (i_pt.in_dist),
        .i_rot    (rot),
        .i_trans  (trans),
        .o_ctl    (ctl3),
        .o_vec    (vec3),
        .o_td     (td3),
        .o_v      (v3),
        .o_dist   (dist3)
    );

    rtpp_plane #(.CW(CW)) u_plane (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (ctl3),
        .i_vec   (vec3),
        .i_td    (td3),
        .i_v     (v3),
        .i_dist  (dist3),
        .o_ctl   (ctl6),
        .o_vec   (vec6),
        .o_dist  (dist6)
    );

    assign res_data = {vec6[0], vec6[1], vec6[2], dist6, ctl6.sat};

    rtpp_skid #(.DW(DW)) u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (ctl6.valid),
        .i_data  (res_data),
        .o_ready (en),
        .o_valid (o_res.valid),
        .o_data  (out_data),
        .i_ready (o_res.ready)
    );

    assign o_res.out_x     = out_data[4*CW -: CW];
    assign o_res.out_y     = out_data[3*CW -: CW];
    assign o_res.out_z     = out_data[2*CW -: CW];
    assign o_res.out_dist  = out_data[CW -: CW];
    assign o_res.saturated = out_data[0];

endmodule

[test/tb_rigid_transform_points_planes.sv]
// ============================================================================
// tb_rigid_transform_points_planes
// Self-checking bench for the rigid point / plane transform.
// A queue-fed driver pushes points and plane equations into the input channel,
// and each accepted beat is transformed by a local fixed-point model into an
// expected result. A monitor compares every result beat field by field.
// The APB registers are written only while the block is drained, and read back.
// The run covers reset values, extreme and saturating settings, random
// settings, changing idle rates on both sides and a long output stall.
// ============================================================================
module tb_rigid_transform_points_planes;
    timeunit 1ns;
    timeprecision 1ps;

    import rtpp_pkg::*;

    localparam int COORD_W       = 32;
    localparam int ROT_FRAC_BITS = 16;
    localparam int ROT_ENTRY_W   = ROT_FRAC_BITS + 2;
    localparam int REG_COUNT     = 6;
    localparam int STALL_LIMIT   = 4000;
    localparam int DRAIN_PAD     = 12;
    localparam int LONG_HOLD     = 300;

    localparam logic [COORD_W-1:0]     C_MAX   = 32'h7FFF_FFFF;
    localparam logic [COORD_W-1:0]     C_MIN   = 32'h8000_0000;
    localparam logic [ROT_ENTRY_W-1:0] ROT_MAX = 18'h1_FFFF;
    localparam logic [ROT_ENTRY_W-1:0] ROT_MIN = 18'h2_0000;
    localparam logic [ROT_ENTRY_W-1:0] ROT_ONE = 18'h1_0000;
    localparam logic [ROT_ENTRY_W-1:0] ROT_0   = '0;

    typedef struct packed {
        t_opcode                    op;
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic signed [COORD_W-1:0]  z;
        logic signed [COORD_W-1:0]  d;
    } t_item;

    typedef struct packed {
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic signed [COORD_W-1:0]  z;
        logic signed [COORD_W-1:0]  d;
        logic                       sat;
    } t_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    rtpp_pt_if  #(.CW(COORD_W)) pt_bus ();
    rtpp_res_if #(.CW(COORD_W)) res_bus ();

    rigid_transform_points_planes #(
        .COORD_WIDTH   (COORD_W),
        .ROT_FRAC_BITS (ROT_FRAC_BITS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_pt    (pt_bus),
        .o_res   (res_bus)
    );

    // register shadow
    logic [ROT_REG_W-1:0] rot_cols [3];
    longint               trans_vec [3];

    t_item   pending_q [$];
    t_result expected_q [$];
    t_item   cur_item;

    int send_idle_pct;
    int recv_idle_pct;
    int hold_len;
    int hold_req;
    int hold_seen;
    int hold_cnt;
    int n_queued;
    int n_accepted;
    int n_planes;
    int n_results;
    int n_sat;
    int n_configs;
    int n_errors;
    int stall_cycles;

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    task automatic report(input string msg);
        if (n_errors < 40)
            $display("MISMATCH @%0t: %s", $realtime, msg);
        n_errors++;
    endtask

    // ------------------------------------------------------------------------
    // fixed-point model
    // ------------------------------------------------------------------------
    function automatic longint rot_entry(int col, int row);
        logic [ROT_ENTRY_W-1:0] e;
        e = rot_cols[col][row*ROT_ENTRY_W +: ROT_ENTRY_W];
        return longint'($signed(e));
    endfunction

    // |a*b| >> sh toward zero, magnitude capped
    function automatic longint mul_trunc(longint a, longint b, int sh);
        logic [127:0] ma;
        logic [127:0] mb;
        logic [127:0] mag;
        logic         neg;
        neg = (a < 0) != (b < 0);
        ma  = (a < 0) ? 128'(-a) : 128'(a);
        mb  = (b < 0) ? 128'(-b) : 128'(b);
        mag = (ma * mb) >> sh;
        if (mag > (128'd1 << PROD_LIM_LOG2))
            mag = 128'd1 << PROD_LIM_LOG2;
        return neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
    endfunction

    // {clamped, value}
    function automatic logic [COORD_W:0] clamp_coord(longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (COORD_W - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            return {1'b1, COORD_W'(hi)};
        if (v < lo)
            return {1'b1, COORD_W'(lo)};
        return {1'b0, COORD_W'(v)};
    endfunction

    function automatic t_result transform(t_item it);
        t_result          r;
        longint           v [3];
        longint           acc;
        longint           td;
        logic [COORD_W:0] c;
        logic [COORD_W-1:0] vec [3];
        r.sat = 1'b0;
        v[0] = longint'(it.x);
        v[1] = longint'(it.y);
        v[2] = longint'(it.z);
        for (int i = 0; i < 3; i++) begin
            acc = (it.op == OP_PLANE) ? 0 : trans_vec[i];
            for (int k = 0; k < 3; k++)
                acc += mul_trunc(rot_entry(k, i), v[k], ROT_FRAC_BITS);
            c = clamp_coord(acc);
            r.sat |= c[COORD_W];
            vec[i] = c[COORD_W-1:0];
        end
        r.x = vec[0];
        r.y = vec[1];
        r.z = vec[2];
        r.d = '0;
        if (it.op == OP_PLANE) begin
            acc = longint'(it.d);
            for (int k = 0; k < 3; k++) begin
                td = 0;
                for (int i = 0; i < 3; i++)
                    td += mul_trunc(rot_entry(k, i), -trans_vec[i], ROT_FRAC_BITS);
                c = clamp_coord(td);
                r.sat |= c[COORD_W];
                td = longint'($signed(c[COORD_W-1:0]));
                acc += mul_trunc(v[k], td, COORD_FRAC);
            end
            c = clamp_coord(acc);
            r.sat |= c[COORD_W];
            r.d = c[COORD_W-1:0];
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // APB access
    // ------------------------------------------------------------------------
    task automatic cfg_write(input int idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(idx << CFG_IDX_LSB);
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx <= REG_ROT_COL2)
            rot_cols[idx] = data[ROT_REG_W-1:0];
        else if (idx < REG_COUNT)
            trans_vec[idx - REG_TRANS_X] = longint'($signed(data[COORD_W-1:0]));
    endtask

    task automatic cfg_check();
        logic [CFG_DATA_W-1:0] got;
        for (int idx = REG_ROT_COL0; idx < REG_COUNT; idx++) begin
            @(posedge i_clk);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            paddr   <= CFG_ADDR_W'(idx << CFG_IDX_LSB);
            @(posedge i_clk);
            penable <= 1'b1;
            @(negedge i_clk);
            got = prdata;
            do @(posedge i_clk); while (!pready);
            psel    <= 1'b0;
            penable <= 1'b0;
            if (idx <= REG_ROT_COL2) begin
                if (got[ROT_REG_W-1:0] !== rot_cols[idx])
                    report($sformatf("reg %0d read %h expected %h", idx,
                                     got[ROT_REG_W-1:0], rot_cols[idx]));
            end else if (got[COORD_W-1:0] !== trans_vec[idx - REG_TRANS_X][COORD_W-1:0]) begin
                report($sformatf("reg %0d read %h expected %h", idx, got[COORD_W-1:0],
                                 trans_vec[idx - REG_TRANS_X][COORD_W-1:0]));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [CFG_DATA_W-1:0] rot_word(
        logic [ROT_ENTRY_W-1:0] ex, logic [ROT_ENTRY_W-1:0] ey,
        logic [ROT_ENTRY_W-1:0] ez, logic [9:0] junk);
        return {junk, ez, ey, ex};
    endfunction

    function automatic logic [COORD_W-1:0] rand_coord();
        case ($urandom_range(9))
            0:       return C_MAX;
            1:       return C_MIN;
            2:       return '0;
            3, 4, 5: return COORD_W'($urandom);
            default: return COORD_W'($urandom_range(32'h0080_0000)) - 32'h0040_0000;
        endcase
    endfunction

    function automatic logic [ROT_ENTRY_W-1:0] rand_rot();
        case ($urandom_range(7))
            0:       return ROT_MAX;
            1:       return ROT_MIN;
            2, 3:    return ROT_ENTRY_W'($urandom);
            default: return ROT_ENTRY_W'($urandom_range(32'h2_0000)) - ROT_ONE;
        endcase
    endfunction

    task automatic push_item(input t_opcode op, input logic [COORD_W-1:0] x,
                             input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z,
                             input logic [COORD_W-1:0] d);
        pending_q.push_back('{op, x, y, z, d});
        n_queued++;
    endtask

    task automatic drain();
        while (n_accepted != n_queued || expected_q.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_PAD) @(negedge i_clk);
    endtask

    task automatic rand_config();
        for (int idx = REG_ROT_COL0; idx <= REG_ROT_COL2; idx++)
            cfg_write(idx, rot_word(rand_rot(), rand_rot(), rand_rot(),
                                    10'($urandom)));
        for (int idx = REG_TRANS_X; idx <= REG_TRANS_Z; idx++)
            cfg_write(idx, {32'($urandom), rand_coord()});
        n_configs++;
    endtask

    task automatic run_random(input int count);
        @(negedge i_clk);
        for (int n = 0; n < count; n++)
            push_item($urandom_range(1) ? OP_PLANE : OP_POINT, rand_coord(),
                      rand_coord(), rand_coord(), rand_coord());
        drain();
    endtask

    // ------------------------------------------------------------------------
    // input driver
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : pt_driver
        logic busy;
        if (!i_rst_n) begin
            pt_bus.valid   <= 1'b0;
            pt_bus.opcode  <= OP_POINT;
            pt_bus.in_x    <= '0;
            pt_bus.in_y    <= '0;
            pt_bus.in_z    <= '0;
            pt_bus.in_dist <= '0;
        end else begin
            busy = pt_bus.valid && !pt_bus.ready;
            if (pt_bus.valid && pt_bus.ready) begin
                expected_q.push_back(transform(cur_item));
                n_accepted++;
                if (cur_item.op == OP_PLANE)
                    n_planes++;
            end
            if (!busy) begin
                if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_item        = pending_q.pop_front();
                    pt_bus.opcode  <= cur_item.op;
                    pt_bus.in_x    <= cur_item.x;
                    pt_bus.in_y    <= cur_item.y;
                    pt_bus.in_z    <= cur_item.z;
                    pt_bus.in_dist <= cur_item.d;
                    pt_bus.valid   <= 1'b1;
                end else begin
                    pt_bus.valid   <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // result monitor and receiver
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : res_monitor
        t_result want;
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
            hold_cnt = 0;
        end else begin
            if (res_bus.valid && res_bus.ready) begin
                if (expected_q.size() == 0) begin
                    report("result beat with nothing expected");
                end else begin
                    want = expected_q.pop_front();
                    n_results++;
                    if (want.sat)
                        n_sat++;
                    if (res_bus.out_x !== want.x)
                        report($sformatf("out_x got %h expected %h", res_bus.out_x, want.x));
                    if (res_bus.out_y !== want.y)
                        report($sformatf("out_y got %h expected %h", res_bus.out_y, want.y));
                    if (res_bus.out_z !== want.z)
                        report($sformatf("out_z got %h expected %h", res_bus.out_z, want.z));
                    if (res_bus.out_dist !== want.d)
                        report($sformatf("out_dist got %h expected %h",
                                         res_bus.out_dist, want.d));
                    if (res_bus.saturated !== want.sat)
                        report($sformatf("saturated got %b expected %b",
                                         res_bus.saturated, want.sat));
                end
            end
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_cnt  = hold_len;
            end
            if (hold_cnt != 0) begin
                hold_cnt--;
                res_bus.ready <= 1'b0;
            end else begin
                res_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if ((pt_bus.valid && pt_bus.ready) || (res_bus.valid && res_bus.ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no beat for %0d cycles", STALL_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n         <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        rot_cols[0]     = ROT_COL0_RST;
        rot_cols[1]     = ROT_COL1_RST;
        rot_cols[2]     = ROT_COL2_RST;
        trans_vec       = '{0, 0, 0};
        send_idle_pct   = 19;
        recv_idle_pct   = 59;
        hold_len        = 0;
        hold_req        = 0;
        hold_seen       = 0;
        n_queued        = 0;
        n_accepted      = 0;
        n_planes        = 0;
        n_results       = 0;
        n_sat           = 0;
        n_configs       = 1;
        n_errors        = 0;
        stall_cycles    = 0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset values
        cfg_check();
        @(negedge i_clk);
        push_item(OP_POINT, '0, '0, '0, '0);
        push_item(OP_POINT, C_MAX, C_MAX, C_MAX, C_MAX);
        push_item(OP_PLANE, C_MIN, C_MIN, C_MIN, C_MAX);
        drain();

        // largest entries, most negative translation, junk in upper bits
        for (int idx = REG_ROT_COL0; idx <= REG_ROT_COL2; idx++)
            cfg_write(idx, rot_word(ROT_MAX, ROT_MAX, ROT_MAX, 10'h3FF));
        for (int idx = REG_TRANS_X; idx <= REG_TRANS_Z; idx++)
            cfg_write(idx, {32'hA5A5_5A5A, C_MIN});
        n_configs++;
        cfg_check();
        @(negedge i_clk);
        push_item(OP_POINT, C_MAX, C_MAX, C_MAX, '0);
        push_item(OP_POINT, C_MIN, C_MIN, C_MIN, C_MIN);
        push_item(OP_POINT, '0, '0, '0, C_MAX);
        push_item(OP_PLANE, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, '0);
        push_item(OP_PLANE, C_MAX, C_MAX, C_MAX, C_MAX);
        push_item(OP_PLANE, C_MIN, C_MIN, C_MIN, C_MIN);
        drain();

        // most negative entries, largest translation, writes past the map
        for (int idx = REG_ROT_COL0; idx <= REG_ROT_COL2; idx++)
            cfg_write(idx, rot_word(ROT_MIN, ROT_MIN, ROT_MIN, '0));
        for (int idx = REG_TRANS_X; idx <= REG_TRANS_Z; idx++)
            cfg_write(idx, {32'hFFFF_FFFF, C_MAX});
        cfg_write(REG_COUNT, {$urandom, $urandom});
        cfg_write(REG_COUNT + 1, {$urandom, $urandom});
        n_configs++;
        cfg_check();
        @(negedge i_clk);
        push_item(OP_POINT, C_MAX, C_MAX, C_MAX, C_MIN);
        push_item(OP_POINT, C_MIN, C_MIN, C_MIN, '0);
        push_item(OP_PLANE, C_MAX, C_MAX, C_MAX, C_MAX);
        push_item(OP_PLANE, C_MAX, C_MIN, '0, C_MAX);
        push_item(OP_PLANE, '0, '0, '0, C_MIN);
        drain();

        // identity rotation with a small offset
        cfg_write(REG_ROT_COL0, rot_word(ROT_ONE, ROT_0, ROT_0, '0));
        cfg_write(REG_ROT_COL1, rot_word(ROT_0, ROT_ONE, ROT_0, '0));
        cfg_write(REG_ROT_COL2, rot_word(ROT_0, ROT_0, ROT_ONE, '0));
        cfg_write(REG_TRANS_X, 64'h0001_8000);
        cfg_write(REG_TRANS_Y, 64'hFFFD_C000);
        cfg_write(REG_TRANS_Z, 64'h0003_0000);
        n_configs++;
        @(negedge i_clk);
        push_item(OP_POINT, 32'h0002_0000, 32'hFFFF_0000, 32'h0000_8000, '0);
        push_item(OP_PLANE, 32'h0000_B505, 32'h0000_B505, '0, 32'h0004_0000);
        drain();

        // random part: three idle mixes, several settings each
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 19; recv_idle_pct = 59; end
                1: begin send_idle_pct = 59; recv_idle_pct = 19; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int set = 0; set < 4; set++) begin
                rand_config();
                cfg_check();
                run_random(125);
            end
        end

        // long output stall while the input keeps offering beats
        rand_config();
        @(negedge i_clk);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_len      = LONG_HOLD;
        hold_req++;
        run_random(50);

        drain();
        repeat (20) @(posedge i_clk);
        $display("Covered %0d beats (%0d planes) over %0d register settings.",
                 n_accepted, n_planes, n_configs);
        $display("Checked %0d results, %0d of them saturated; %0d mismatches.",
                 n_results, n_sat, n_errors);
        if (n_errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[rigid_transform_points_planes.f]
rtl/rtpp_pkg.sv
rtl/rtpp_pt_if.sv
rtl/rtpp_res_if.sv
rtl/rtpp_regs.sv
rtl/rtpp_xform.sv
rtl/rtpp_plane.sv
rtl/rtpp_skid.sv
rtl/rigid_transform_points_planes.sv
test/tb_rigid_transform_points_planes.sv
